// ===== src/kmss_pkg.sv =====
// ----------------------------------------------------------------------------
// kmss_pkg: shared types and constants of the k-mer segment scorer
// Beat formats, field widths and the control word passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package kmss_pkg;

   localparam int CODE_W   = 3;
   localparam int INDEX_W  = 13;
   localparam int WEIGHT_W = 32;
   localparam int SCORE_W  = 48;
   localparam int COUNT_W  = 20;
   localparam int CFG_W    = 3;

   // Window length after reset.
   localparam int CFG_RESET = 3;

   localparam logic              REQ_LOAD = 1'b0;
   localparam logic              REQ_BASE = 1'b1;
   localparam logic [CODE_W-1:0] BASE_N   = 3'd4;

   typedef struct packed {
      logic                       req_type;
      logic [CODE_W-1:0]          base_code;
      logic                       segment_first;
      logic                       segment_last;
      logic [INDEX_W-1:0]         table_index;
      logic signed [WEIGHT_W-1:0] table_weight;
   } req_beat_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] segment_score;
      logic [COUNT_W-1:0]        windows_scored;
      logic                      score_saturated;
   } rsp_beat_type;

   // Per-base control word handed from the window tracker to the accumulator.
   typedef struct packed {
      logic clean;       // the window after this base holds no N
      logic start_term;  // first clean window of the segment
      logic seg_first;
      logic seg_last;
      logic win_ok;      // window entry lies inside the table
      logic start_ok;    // prefix entry lies inside the table
   } s1_ctl_type;

endpackage

`default_nettype wire

// ===== src/markov_kmer_segment_scorer_core.sv =====
// ----------------------------------------------------------------------------
// markov_kmer_segment_scorer_core: Markov k-mer segment log-likelihood scorer
// Throughput: one beat per cycle, bases and table loads alike, while req_stall
// is low; the rate is set by the single accumulate stage fed from the two read
// ports of the table.
// Reset: synchronous, clears the window, the segment state and the result
// valid flag; the window length returns to 3; the weight table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

// Two stages carry a base beat. At acceptance the window tracker shifts the
// base in, decides whether the window is clean and issues two table reads:
// one for the window entry and one for the entry of its prefix, which is only
// used on the first clean window of a segment. In the next cycle the read data
// is registered and the accumulator adds it with saturation. On the last base
// of a segment the result beat is loaded into the output register.
//
// A table load beat writes the memory at the edge it is accepted. A base beat
// that follows reads at a later edge, so it always sees the new weight and no
// forwarding path is needed.
//
// The input is stalled only when the accumulate stage holds a last base whose
// result cannot yet enter the output register. A beat without a result passes
// the stage even while a result waits downstream.

module markov_kmer_segment_scorer_core #(
   parameter int MAX_WINDOW  = 6,
   parameter int TABLE_DEPTH = 5120
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire kmss_pkg::req_beat_type        req_beat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output kmss_pkg::rsp_beat_type             rsp_beat,
   input  wire logic                          csr_wr_en,
   input  wire logic [kmss_pkg::CFG_W-1:0]    csr_wr_data
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CD_W = $clog2(MAX_WINDOW + 1);

   logic [kmss_pkg::CFG_W-1:0] window_length_ff, window_length_in;
   logic [CD_W-1:0]            k_len;
   logic                       accept, issue, load_we;
   logic [31:0]                load_idx;
   kmss_pkg::s1_ctl_type       ctl_new;
   logic [AW-1:0]              win_addr, start_addr;
   logic signed [kmss_pkg::WEIGHT_W-1:0] win_weight, start_weight;
   logic                       hold;

   // Window length register. Zero behaves as one base and anything above the
   // largest supported window behaves as the largest window.
   assign window_length_in = csr_wr_en ? csr_wr_data : window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= kmss_pkg::CFG_W'(kmss_pkg::CFG_RESET);
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   always_comb begin
      if (window_length_ff == '0) begin
         k_len = CD_W'(1);
      end else if (32'(window_length_ff) > 32'(MAX_WINDOW)) begin
         k_len = CD_W'(MAX_WINDOW);
      end else begin
         k_len = CD_W'(window_length_ff);
      end
   end

   // Handshake. A beat is taken whenever the accumulate stage is not held.
   assign req_stall = hold;
   assign accept    = req_valid & ~req_stall;
   assign issue     = accept & (req_beat.req_type == kmss_pkg::REQ_BASE);

   // Loads outside the table are dropped.
   assign load_idx = 32'(req_beat.table_index);
   assign load_we  = accept & (req_beat.req_type == kmss_pkg::REQ_LOAD)
                     & (load_idx < 32'(TABLE_DEPTH));

   kmss_window_ctl #(
      .MAX_WINDOW  (MAX_WINDOW),
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CD_W        (CD_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .base_code  (req_beat.base_code),
      .seg_first  (req_beat.segment_first),
      .seg_last   (req_beat.segment_last),
      .k_len      (k_len),
      .ctl        (ctl_new),
      .win_addr   (win_addr),
      .start_addr (start_addr)
   );

   kmss_weight_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (load_we),
      .wr_addr   (load_idx[AW-1:0]),
      .wr_data   (req_beat.table_weight),
      .rd_en     (issue),
      .rd_addr_a (win_addr),
      .rd_addr_b (start_addr),
      .rd_data_a (win_weight),
      .rd_data_b (start_weight)
   );

   kmss_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .ctl_new      (ctl_new),
      .win_weight   (win_weight),
      .start_weight (start_weight),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_beat     (rsp_beat),
      .hold         (hold)
   );

endmodule

`default_nettype wire

// ===== src/kmss_weight_mem.sv =====
// ----------------------------------------------------------------------------
// kmss_weight_mem: weight table storage
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmss_weight_mem #(
   parameter int DEPTH = 5120,
   parameter int AW    = 13
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [AW-1:0]                         wr_addr,
   input  wire logic signed [kmss_pkg::WEIGHT_W-1:0]  wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [AW-1:0]                         rd_addr_a,
   input  wire logic [AW-1:0]                         rd_addr_b,
   output logic signed [kmss_pkg::WEIGHT_W-1:0]       rd_data_a,
   output logic signed [kmss_pkg::WEIGHT_W-1:0]       rd_data_b
);

   logic signed [kmss_pkg::WEIGHT_W-1:0] mem_ff [DEPTH];
   logic signed [kmss_pkg::WEIGHT_W-1:0] rd_a_ff;
   logic signed [kmss_pkg::WEIGHT_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== src/kmss_window_ctl.sv =====
// ----------------------------------------------------------------------------
// kmss_window_ctl: base window tracker
// Shifts bases into the window, counts down to a clean window and forms the
// two table addresses for each base beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kmss_window_ctl #(
   parameter int MAX_WINDOW  = 6,
   parameter int TABLE_DEPTH = 5120,
   parameter int AW          = 13,
   parameter int CD_W        = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            issue,
   input  wire logic [kmss_pkg::CODE_W-1:0]     base_code,
   input  wire logic                            seg_first,
   input  wire logic                            seg_last,
   input  wire logic [CD_W-1:0]                 k_len,
   output kmss_pkg::s1_ctl_type                 ctl,
   output logic [AW-1:0]                        win_addr,
   output logic [AW-1:0]                        start_addr
);

   localparam int WW      = 2 * MAX_WINDOW;
   localparam int K_RESET = (kmss_pkg::CFG_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                : kmss_pkg::CFG_RESET;

   logic [WW-1:0]   win_ff, win_in, win_src, win_next, win_mask;
   logic [CD_W-1:0] cd_ff, cd_in, cd_src, cd_min, cd_next;
   logic            done_ff, done_in, done_src;
   logic            clean;
   logic [31:0]     span, win_idx, start_idx;

   always_comb begin
      win_mask = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         win_mask[2*i +: 2] = (CD_W'(i) < k_len) ? 2'b11 : 2'b00;
      end
   end

   always_comb begin
      win_src  = seg_first ? '0 : win_ff;
      cd_src   = seg_first ? k_len : cd_ff;
      done_src = seg_first ? 1'b0 : done_ff;
      cd_min   = (cd_src > k_len) ? k_len : cd_src;
      if (base_code >= kmss_pkg::BASE_N) begin
         win_next = win_src;
         cd_next  = k_len;
         clean    = 1'b0;
      end else begin
         win_next = ((win_src << 2) | WW'(base_code[1:0])) & win_mask;
         cd_next  = (cd_min == '0) ? '0 : cd_min - CD_W'(1);
         clean    = (cd_next == '0);
      end
   end

   always_comb begin
      span       = 32'd1 << (2 * k_len);
      win_idx    = 32'(win_next);
      start_idx  = span + 32'(win_next >> 2);
      win_addr   = win_idx[AW-1:0];
      start_addr = start_idx[AW-1:0];

      ctl.clean      = clean;
      ctl.start_term = clean & ~done_src;
      ctl.seg_first  = seg_first;
      ctl.seg_last   = seg_last;
      ctl.win_ok     = win_idx < 32'(TABLE_DEPTH);
      ctl.start_ok   = start_idx < 32'(TABLE_DEPTH);
   end

   // The emission at the last base clears the window for the next segment.
   always_comb begin
      win_in  = win_ff;
      cd_in   = cd_ff;
      done_in = done_ff;
      if (issue) begin
         if (seg_last) begin
            win_in  = '0;
            cd_in   = k_len;
            done_in = 1'b0;
         end else begin
            win_in  = win_next;
            cd_in   = cd_next;
            done_in = done_src | clean;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         cd_ff   <= CD_W'(K_RESET);
         done_ff <= 1'b0;
      end else begin
         win_ff  <= win_in;
         cd_ff   <= cd_in;
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/kmss_accum.sv =====
// ----------------------------------------------------------------------------
// kmss_accum: score accumulator and result register
// Adds the weights read for each base, saturates, counts windows and holds
// the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kmss_accum (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  issue,
   input  wire kmss_pkg::s1_ctl_type                  ctl_new,
   input  wire logic signed [kmss_pkg::WEIGHT_W-1:0]  win_weight,
   input  wire logic signed [kmss_pkg::WEIGHT_W-1:0]  start_weight,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_valid,
   output kmss_pkg::rsp_beat_type                     rsp_beat,
   output logic                                       hold
);

   localparam int SW = kmss_pkg::SCORE_W;
   localparam int WTW = kmss_pkg::WEIGHT_W;

   logic                    s1_valid_ff, s1_valid_in;
   kmss_pkg::s1_ctl_type    s1_ctl_ff;
   logic signed [SW-1:0]    acc_ff, acc_in, acc_base, acc_sum, addend_a;
   logic [kmss_pkg::COUNT_W-1:0] cnt_ff, cnt_in, cnt_base, cnt_sum;
   logic                    sat_ff, sat_in, sat_base, sat_sum;
   logic signed [SW:0]      sum_wide;
   logic signed [WTW-1:0]   w_win, w_start;
   logic                    out_free, advance, emit;
   logic                    rsp_valid_ff, rsp_valid_in;
   kmss_pkg::rsp_beat_type  rsp_beat_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign advance  = s1_valid_ff & (~s1_ctl_ff.seg_last | out_free);
   assign emit     = advance & s1_ctl_ff.seg_last;
   assign hold     = s1_valid_ff & ~advance;

   // The start term only ever meets an empty accumulator, so the first clean
   // window adds start and window weights directly without any clamping risk.
   always_comb begin
      acc_base = s1_ctl_ff.seg_first ? '0 : acc_ff;
      cnt_base = s1_ctl_ff.seg_first ? '0 : cnt_ff;
      sat_base = s1_ctl_ff.seg_first ? 1'b0 : sat_ff;
      w_win    = s1_ctl_ff.win_ok ? win_weight : '0;
      w_start  = s1_ctl_ff.start_ok ? start_weight : '0;
      addend_a = s1_ctl_ff.start_term ? SW'(w_start) : acc_base;
      sum_wide = (SW+1)'(addend_a) + (SW+1)'(w_win);
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         acc_sum = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
         sat_sum = 1'b1;
      end else begin
         acc_sum = sum_wide[SW-1:0];
         sat_sum = sat_base;
      end
      cnt_sum = cnt_base + kmss_pkg::COUNT_W'(cnt_base != '1);
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      sat_in = sat_ff;
      if (advance) begin
         if (s1_ctl_ff.seg_last) begin
            acc_in = '0;
            cnt_in = '0;
            sat_in = 1'b0;
         end else if (s1_ctl_ff.clean) begin
            acc_in = acc_sum;
            cnt_in = cnt_sum;
            sat_in = sat_sum;
         end else begin
            acc_in = acc_base;
            cnt_in = cnt_base;
            sat_in = sat_base;
         end
      end
   end

   assign s1_valid_in = issue | hold;

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         sat_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ctl_ff <= ctl_new;
      end
      if (emit) begin
         rsp_beat_ff.segment_score   <= s1_ctl_ff.clean ? acc_sum : acc_base;
         rsp_beat_ff.windows_scored  <= s1_ctl_ff.clean ? cnt_sum : cnt_base;
         rsp_beat_ff.score_saturated <= s1_ctl_ff.clean ? sat_sum : sat_base;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   a_no_issue_on_hold: assert property (@(posedge clock) disable iff (reset)
      (issue && s1_valid_ff) |-> advance)
      else $error("new base issued while the accumulate stage is held");

   a_hold_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      hold |=> (s1_valid_ff && $stable(s1_ctl_ff)))
      else $error("held accumulate stage lost its beat");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (acc_ff == '0 && cnt_ff == '0 && !sat_ff))
      else $error("segment state not cleared after a result");

   a_empty_segment_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beat_ff.windows_scored == '0) |->
         (rsp_beat_ff.segment_score == '0 && !rsp_beat_ff.score_saturated))
      else $error("segment without windows reports a nonzero score");

endmodule

`default_nettype wire

// ===== tb/sv/markov_kmer_segment_scorer_core_tb.sv =====
// ----------------------------------------------------------------------------
// markov_kmer_segment_scorer_core_tb: self-checking bench of the segment scorer
// Streams table loads and base beats into the scorer with random gaps and
// random result back-pressure. A scoring model inside the bench follows every
// accepted beat and queues the segment result it implies. Each result beat is
// then compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`default_nettype none

module markov_kmer_segment_scorer_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_MAX    = 6;
   localparam int TABLE_ENTRIES = 5120;
   localparam int STALL_LIMIT   = 1000;
   localparam int PHASE_BEATS   = 75;
   localparam logic signed [63:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
   localparam logic [kmss_pkg::COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [kmss_pkg::WEIGHT_W-1:0] WEIGHT_TOP = 32'h7FFF_FFFF;
   localparam logic [kmss_pkg::WEIGHT_W-1:0] WEIGHT_BOTTOM = 32'h8000_0000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   kmss_pkg::req_beat_type     req_beat = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   kmss_pkg::rsp_beat_type     rsp_beat;
   logic                       csr_wr_en = 1'b0;
   logic [kmss_pkg::CFG_W-1:0] csr_wr_data = '0;

   markov_kmer_segment_scorer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Beats waiting to be driven, and the segment results the scoring model
   // expects from the beats that were already accepted.
   kmss_pkg::req_beat_type pending_beats[$];
   kmss_pkg::rsp_beat_type expected_scores[$];

   int  pushed_count = 0;
   int  sent_count = 0;
   int  mismatch_count = 0;
   int  send_gap = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;

   // Window the scorer will hold once every queued beat is taken, and the
   // table entries that some queued load writes. Together they let the
   // stimulus load an entry just before the first base that may read it.
   int unsigned gen_window = 0;
   bit          written [TABLE_ENTRIES];

   // ------------------------------------------------------------------------
   // Scoring model. It keeps its own copy of the weight table, the window
   // length register and the per-segment state of the scorer.
   // ------------------------------------------------------------------------
   logic signed [kmss_pkg::WEIGHT_W-1:0] weight_mem [0:TABLE_ENTRIES-1];
   logic [kmss_pkg::CFG_W-1:0]   window_len_reg = kmss_pkg::CFG_RESET[kmss_pkg::CFG_W-1:0];
   int unsigned                  recent_bases;
   int unsigned                  bases_to_clean;
   bit                           prefix_added;
   logic signed [63:0]           segment_sum;
   logic [kmss_pkg::COUNT_W-1:0] clean_windows;
   bit                           sum_clamped;

   // A register value of zero acts as one and anything past the largest
   // supported window acts as the largest window.
   function automatic int unsigned bases_per_window();
      if (window_len_reg == 0)
         return 1;
      if (window_len_reg > WINDOW_MAX)
         return WINDOW_MAX;
      return 32'(window_len_reg);
   endfunction

   function automatic logic signed [63:0] weight_at(int unsigned addr);
      if (addr >= TABLE_ENTRIES)
         return 64'sd0;
      return 64'(weight_mem[addr]);
   endfunction

   // Saturating add into the Q32.16 segment sum.
   function automatic void add_weight(logic signed [63:0] w);
      logic signed [63:0] s;
      s = segment_sum + w;
      if (s > SUM_MAX) begin
         s = SUM_MAX;
         sum_clamped = 1'b1;
      end
      if (s < SUM_MIN) begin
         s = SUM_MIN;
         sum_clamped = 1'b1;
      end
      segment_sum = s;
   endfunction

   function automatic void clear_segment();
      recent_bases   = 0;
      bases_to_clean = bases_per_window();
      prefix_added   = 1'b0;
      segment_sum    = '0;
      clean_windows  = '0;
      sum_clamped    = 1'b0;
   endfunction

   function automatic void score_beat(kmss_pkg::req_beat_type b);
      int unsigned            k;
      int unsigned            span;
      kmss_pkg::rsp_beat_type r;
      k = bases_per_window();
      if (b.req_type == kmss_pkg::REQ_LOAD) begin
         // Loads past the end of the table are dropped by the scorer.
         if (b.table_index < TABLE_ENTRIES)
            weight_mem[b.table_index] = b.table_weight;
         return;
      end
      if (b.segment_first)
         clear_segment();
      if (b.base_code >= kmss_pkg::BASE_N) begin
         // An N, or any code above it, spoils the next k windows.
         bases_to_clean = k;
      end else begin
         span = 32'd1 << (2 * k);
         recent_bases = ((recent_bases << 2) | 32'(b.base_code)) & (span - 1);
         if (bases_to_clean > k)
            bases_to_clean = k;
         if (bases_to_clean > 0)
            bases_to_clean--;
         if (bases_to_clean == 0) begin
            // The first clean window also brings the start weight of its
            // prefix, stored after the window entries.
            if (!prefix_added) begin
               add_weight(weight_at(span + (recent_bases >> 2)));
               prefix_added = 1'b1;
            end
            add_weight(weight_at(recent_bases));
            if (clean_windows < COUNT_MAX)
               clean_windows++;
         end
      end
      if (b.segment_last) begin
         r.segment_score   = segment_sum[kmss_pkg::SCORE_W-1:0];
         r.windows_scored  = clean_windows;
         r.score_saturated = sum_clamped;
         expected_scores.push_back(r);
         clear_segment();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. After each accepted beat it draws a random idle gap before
   // the next one. The model is updated at the very edge the beat is taken, so
   // the expectation is queued well before the result can come out.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic nxt_valid;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            score_beat(req_beat);
            sent_count++;
            send_gap  = $urandom_range(0, 6);
            nxt_valid = 1'b0;
         end
         // A stalled beat is never touched; a new one is loaded only once the
         // previous one is gone and its gap has run out.
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_beats.size() > 0) begin
               req_beat  <= pending_beats.pop_front();
               nxt_valid = 1'b1;
            end
         end
      end
      req_valid <= nxt_valid;
   end

   // ------------------------------------------------------------------------
   // Result monitor. Each accepted result beat is checked against the oldest
   // expectation; then a random hold of the stall is drawn.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      kmss_pkg::rsp_beat_type want;
      logic                   nxt_stall;
      nxt_stall = 1'b0;
      if (reset) begin
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with no segment pending: score %0d windows %0d",
                           $realtime, rsp_beat.segment_score, rsp_beat.windows_scored);
            end else begin
               want = expected_scores.pop_front();
               if (rsp_beat.segment_score !== want.segment_score ||
                   rsp_beat.windows_scored !== want.windows_scored ||
                   rsp_beat.score_saturated !== want.score_saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: segment mismatch: score exp %0d got %0d, ",
                               "windows exp %0d got %0d, saturated exp %0b got %0b"},
                              $realtime, want.segment_score, rsp_beat.segment_score,
                              want.windows_scored, rsp_beat.windows_scored,
                              want.score_saturated, rsp_beat.score_saturated);
               end
            end
            hold_left = $urandom_range(0, 6);
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end
      end
      rsp_stall <= nxt_stall;
   end

   // A hang on either side shows up as a long run of cycles without any beat.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Base beats carry random load fields, which the scorer must ignore.
   function automatic kmss_pkg::req_beat_type base_beat(logic [kmss_pkg::CODE_W-1:0] code,
                                                        logic first, logic last);
      kmss_pkg::req_beat_type b;
      b.req_type      = kmss_pkg::REQ_BASE;
      b.base_code     = code;
      b.segment_first = first;
      b.segment_last  = last;
      b.table_index   = kmss_pkg::INDEX_W'($urandom);
      b.table_weight  = $urandom;
      return b;
   endfunction

   // Load beats likewise carry random base fields.
   function automatic kmss_pkg::req_beat_type load_beat(int unsigned addr,
                                                        logic [kmss_pkg::WEIGHT_W-1:0] w);
      kmss_pkg::req_beat_type b;
      b.req_type      = kmss_pkg::REQ_LOAD;
      b.base_code     = kmss_pkg::CODE_W'($urandom);
      b.segment_first = 1'($urandom);
      b.segment_last  = 1'($urandom);
      b.table_index   = addr[kmss_pkg::INDEX_W-1:0];
      b.table_weight  = w;
      return b;
   endfunction

   function automatic logic [kmss_pkg::WEIGHT_W-1:0] random_weight();
      case ($urandom_range(0, 15))
         0:       return WEIGHT_TOP;
         1:       return WEIGHT_BOTTOM;
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Keeps the pending queue short.
   task automatic push_beat(kmss_pkg::req_beat_type b);
      while (pending_beats.size() >= 256)
         @(posedge clock);
      pending_beats.push_back(b);
      pushed_count++;
   endtask

   // Loads an entry with a random weight unless some earlier load wrote it.
   task automatic fill_entry(int unsigned addr);
      if (addr < TABLE_ENTRIES && !written[addr]) begin
         written[addr] = 1'b1;
         push_beat(load_beat(addr, random_weight()));
      end
   endtask

   // Follows the window the scorer will see for this beat, so that both
   // entries a base may read are written ahead of it and no base ever reads
   // an entry that was never loaded.
   task automatic queue_beat(kmss_pkg::req_beat_type b);
      int unsigned span;
      if (b.req_type == kmss_pkg::REQ_LOAD) begin
         if (b.table_index < TABLE_ENTRIES)
            written[b.table_index] = 1'b1;
      end else begin
         if (b.segment_first)
            gen_window = 0;
         if (b.base_code < kmss_pkg::BASE_N) begin
            span       = 32'd1 << (2 * bases_per_window());
            gen_window = ((gen_window << 2) | 32'(b.base_code)) & (span - 1);
            fill_entry(gen_window);
            fill_entry(span + (gen_window >> 2));
         end
         if (b.segment_last)
            gen_window = 0;
      end
      push_beat(b);
   endtask

   task automatic queue_segment(int unsigned len, int unsigned n_pct);
      logic [kmss_pkg::CODE_W-1:0] code;
      for (int unsigned i = 0; i < len; i++) begin
         code = ($urandom_range(0, 99) < n_pct) ? kmss_pkg::CODE_W'($urandom_range(4, 7))
                                                : kmss_pkg::CODE_W'($urandom_range(0, 3));
         queue_beat(base_beat(code, i == 0, i == len - 1));
      end
   endtask

   // Waits until every queued beat is taken and every result is back, then
   // gives the pipeline time to retire beats that carry no result.
   task automatic settle();
      while (sent_count != pushed_count || expected_scores.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // The window length only changes while the scorer is drained.
   task automatic write_window_length(logic [kmss_pkg::CFG_W-1:0] k);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      window_len_reg = k;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin : run_test
      logic [kmss_pkg::CFG_W-1:0] sweep [8];
      int unsigned                pick;
      int unsigned                len;
      int                         phase_start;

      sweep = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd4, 3'd5, 3'd3};
      clear_segment();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset window length of three.
      // A single base that both opens and closes a segment scores nothing.
      queue_beat(base_beat(3'd0, 1'b1, 1'b1));
      // Four clean bases give two windows plus the start weight.
      queue_beat(base_beat(3'd0, 1'b1, 1'b0));
      queue_beat(base_beat(3'd3, 1'b0, 1'b0));
      queue_beat(base_beat(3'd2, 1'b0, 1'b0));
      queue_beat(base_beat(3'd1, 1'b0, 1'b1));
      // An N in the middle restarts the wait for a clean window.
      queue_beat(base_beat(3'd0, 1'b1, 1'b0));
      queue_beat(base_beat(3'd3, 1'b0, 1'b0));
      queue_beat(base_beat(kmss_pkg::BASE_N, 1'b0, 1'b0));
      queue_beat(base_beat(3'd2, 1'b0, 1'b0));
      queue_beat(base_beat(3'd1, 1'b0, 1'b0));
      queue_beat(base_beat(3'd0, 1'b0, 1'b1));
      // Codes above N behave as N.
      queue_beat(base_beat(3'd5, 1'b1, 1'b0));
      queue_beat(base_beat(3'd1, 1'b0, 1'b0));
      queue_beat(base_beat(3'd6, 1'b0, 1'b0));
      queue_beat(base_beat(3'd7, 1'b0, 1'b1));
      // Extreme weights on the windows of all code 0 and all code 3; loads past
      // the end of the table must leave everything alone.
      queue_beat(load_beat(0, WEIGHT_TOP));
      queue_beat(load_beat(63, WEIGHT_BOTTOM));
      queue_beat(load_beat(TABLE_ENTRIES, WEIGHT_TOP));
      queue_beat(load_beat(8191, WEIGHT_BOTTOM));
      queue_beat(base_beat(3'd0, 1'b1, 1'b0));
      queue_beat(base_beat(3'd0, 1'b0, 1'b0));
      queue_beat(base_beat(3'd0, 1'b0, 1'b1));
      // The segment is opened by the previous result, not by a first mark.
      queue_beat(base_beat(3'd3, 1'b0, 1'b0));
      queue_beat(base_beat(3'd3, 1'b0, 1'b0));
      queue_beat(base_beat(3'd3, 1'b0, 1'b1));

      // Every window length, the out-of-range codes among them.
      foreach (sweep[i]) begin
         write_window_length(sweep[i]);
         queue_segment($urandom_range(1, 12), 10);
         queue_beat(load_beat($urandom_range(0, TABLE_ENTRIES - 1), random_weight()));
         queue_segment($urandom_range(1, 12), 10);
      end

      // Random phases, mostly well-formed segments, with loads and stray
      // bases that open or close segments at random mixed in.
      for (int phase = 0; phase < 8; phase++) begin
         write_window_length(kmss_pkg::CFG_W'($urandom_range(0, 7)));
         phase_start = pushed_count;
         while (pushed_count - phase_start < PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               len = $urandom_range(1, 30);
               queue_segment(len, 8);
            end else if (pick < 90) begin
               queue_beat(load_beat($urandom_range(0, TABLE_ENTRIES - 1), random_weight()));
            end else if (pick < 93) begin
               queue_beat(load_beat($urandom_range(TABLE_ENTRIES, 8191), random_weight()));
            end else begin
               queue_beat(base_beat(kmss_pkg::CODE_W'($urandom_range(0, 7)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
